FILE: rtl/jst_pkg.sv
// ----------------------------------------------------------------------------
// jst_pkg
// Shared types, constants and helpers for the jog/shuttle transport control.
// ----------------------------------------------------------------------------
`default_nettype none

package jst_pkg;

    localparam int FRAME_BITS  = 32;
    localparam int TARGET_BITS = 32;
    localparam int MAX_BITS    = 33;
    localparam int SPEED_BITS  = 6;
    localparam int CMD_BITS    = 3;
    localparam int MODE_BITS   = 2;
    localparam int CMP_BITS    = (FRAME_BITS > TARGET_BITS) ? FRAME_BITS : TARGET_BITS;
    localparam int NUM_RUNGS   = 5;

    localparam logic [FRAME_BITS-1:0] FRAME_TOP = {FRAME_BITS{1'b1}};

    typedef enum logic [CMD_BITS-1:0] {
        CMD_NEW_MEDIA = 3'd0,
        CMD_SET_FRAME = 3'd1,
        CMD_TOGGLE    = 3'd2,
        CMD_PAUSE     = 3'd3,
        CMD_JOG_FWD   = 3'd4,
        CMD_JOG_REV   = 3'd5,
        CMD_STEP_FWD  = 3'd6,
        CMD_STEP_BACK = 3'd7
    } t_cmd;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_PAUSED = 2'd0,
        MODE_FWD    = 2'd1,
        MODE_REV    = 2'd2
    } t_mode;

    typedef logic signed [SPEED_BITS-1:0] t_speed;

    localparam t_speed RUNG_TABLE [NUM_RUNGS] = '{6'sd1, 6'sd2, 6'sd5, 6'sd10, 6'sd30};

    typedef struct packed {
        t_cmd                   cmd;
        logic                   enter_at_two;
        logic [TARGET_BITS-1:0] target_frame;
    } t_item;

    typedef struct packed {
        logic valid;
    } t_stage_ctl;

    typedef struct packed {
        logic advance;
    } t_core_ctl;

    // first rung above mag, holding at the top rung
    function automatic t_speed next_rung(input t_speed mag);
        t_speed r;
        r = RUNG_TABLE[NUM_RUNGS-1];
        for (int i = NUM_RUNGS - 1; i >= 0; i--) begin
            if (RUNG_TABLE[i] > mag) begin
                r = RUNG_TABLE[i];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/jst_cmd_if.sv
// ----------------------------------------------------------------------------
// jst_cmd_if
// Command channel: valid/ready handshake with one transport command per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface jst_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [jst_pkg::CMD_BITS-1:0]    cmd;
    logic                            enter_at_two;
    logic [jst_pkg::TARGET_BITS-1:0] target_frame;

    modport source (output valid, output cmd, output enter_at_two, output target_frame,
                    input ready);
    modport sink   (input valid, input cmd, input enter_at_two, input target_frame,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/jst_res_if.sv
// ----------------------------------------------------------------------------
// jst_res_if
// Result channel: valid/ready handshake with mode, speed and frame per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface jst_res_if;
    logic                           valid;
    logic                           ready;
    logic [jst_pkg::MODE_BITS-1:0]  mode;
    logic [jst_pkg::SPEED_BITS-1:0] speed;
    logic [jst_pkg::FRAME_BITS-1:0] frame;

    modport source (output valid, output mode, output speed, output frame, input ready);
    modport sink   (input valid, input mode, input speed, input frame, output ready);
endinterface

`default_nettype wire

FILE: rtl/jst_in_stage.sv
// ----------------------------------------------------------------------------
// jst_in_stage
// Input register for the command channel.
// ----------------------------------------------------------------------------
`default_nettype none

module jst_in_stage (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    jst_cmd_if.sink                 i_cmd,
    input  wire jst_pkg::t_core_ctl i_core_ctl,
    output jst_pkg::t_stage_ctl     o_stage_ctl,
    output jst_pkg::t_item          o_item
);

    logic           r_valid;
    jst_pkg::t_item r_item;
    logic           accept;

    assign i_cmd.ready = !r_valid || i_core_ctl.advance;
    assign accept      = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_core_ctl.advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.cmd          <= jst_pkg::t_cmd'(i_cmd.cmd);
            r_item.enter_at_two <= i_cmd.enter_at_two;
            r_item.target_frame <= i_cmd.target_frame;
        end
    end

    assign o_stage_ctl.valid = r_valid;
    assign o_item            = r_item;

endmodule

`default_nettype wire

FILE: rtl/jst_core.sv
// ----------------------------------------------------------------------------
// jst_core
// Transport state update (mode, stride, frame) and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module jst_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic signed [jst_pkg::MAX_BITS-1:0] i_cfg_wdata,
    input  wire jst_pkg::t_stage_ctl                 i_stage_ctl,
    input  wire jst_pkg::t_item                      i_item,
    output jst_pkg::t_core_ctl                       o_core_ctl,
    jst_res_if.source                                o_res
);

    logic signed [jst_pkg::MAX_BITS-1:0]   r_max_frame;
    jst_pkg::t_mode                        r_mode;
    jst_pkg::t_speed                       r_stride;
    logic [jst_pkg::FRAME_BITS-1:0]        r_position;
    logic                                  r_out_valid;
    jst_pkg::t_mode                        r_out_mode;
    jst_pkg::t_speed                       r_out_speed;
    logic [jst_pkg::FRAME_BITS-1:0]        r_out_frame;

    jst_pkg::t_mode                        n_mode;
    jst_pkg::t_speed                       n_stride;
    logic [jst_pkg::FRAME_BITS-1:0]        n_position;

    logic                                  advance;
    logic                                  take;
    jst_pkg::t_speed                       entry;
    logic [jst_pkg::FRAME_BITS-1:0]        step_up;
    logic [jst_pkg::FRAME_BITS-1:0]        step_down;
    logic [jst_pkg::FRAME_BITS-1:0]        clamp_in;

    // saturate to the frame range, then to max_frame when it is not negative
    function automatic logic [jst_pkg::FRAME_BITS-1:0] clamp_frame(
        input logic [jst_pkg::CMP_BITS-1:0]        p,
        input logic signed [jst_pkg::MAX_BITS-1:0] max_frame
    );
        logic [jst_pkg::CMP_BITS-1:0] q;
        logic [jst_pkg::CMP_BITS-1:0] cap;
        q   = p;
        cap = jst_pkg::CMP_BITS'(max_frame[jst_pkg::MAX_BITS-2:0]);
        if (q > jst_pkg::CMP_BITS'(jst_pkg::FRAME_TOP)) begin
            q = jst_pkg::CMP_BITS'(jst_pkg::FRAME_TOP);
        end
        if (!max_frame[jst_pkg::MAX_BITS-1] && q > cap) begin
            q = cap;
        end
        return jst_pkg::FRAME_BITS'(q);
    endfunction

    assign advance            = !r_out_valid || o_res.ready;
    assign take               = i_stage_ctl.valid && advance;
    assign o_core_ctl.advance = advance;

    assign entry     = i_item.enter_at_two ? jst_pkg::RUNG_TABLE[1] : jst_pkg::RUNG_TABLE[0];
    assign step_up   = (r_position != jst_pkg::FRAME_TOP) ?
                       r_position + jst_pkg::FRAME_BITS'(1) : r_position;
    assign step_down = (r_position != '0) ? r_position - jst_pkg::FRAME_BITS'(1) : r_position;

    always_comb begin
        case (i_item.cmd)
            jst_pkg::CMD_STEP_FWD:  clamp_in = step_up;
            jst_pkg::CMD_STEP_BACK: clamp_in = step_down;
            default:                clamp_in = r_position;
        endcase
    end

    always_comb begin
        n_mode     = r_mode;
        n_stride   = r_stride;
        n_position = r_position;
        case (i_item.cmd)
            jst_pkg::CMD_NEW_MEDIA: begin
                n_mode     = jst_pkg::MODE_PAUSED;
                n_stride   = '0;
                n_position = '0;
            end
            jst_pkg::CMD_SET_FRAME: begin
                n_position = clamp_frame(jst_pkg::CMP_BITS'(i_item.target_frame), r_max_frame);
            end
            jst_pkg::CMD_TOGGLE: begin
                if (r_mode == jst_pkg::MODE_FWD || r_mode == jst_pkg::MODE_REV) begin
                    n_mode   = jst_pkg::MODE_PAUSED;
                    n_stride = '0;
                end else begin
                    n_mode   = jst_pkg::MODE_FWD;
                    n_stride = jst_pkg::RUNG_TABLE[0];
                end
            end
            jst_pkg::CMD_PAUSE: begin
                n_mode   = jst_pkg::MODE_PAUSED;
                n_stride = '0;
            end
            jst_pkg::CMD_JOG_FWD: begin
                n_mode   = jst_pkg::MODE_FWD;
                n_stride = (r_stride <= 6'sd0) ? entry : jst_pkg::next_rung(r_stride);
            end
            jst_pkg::CMD_JOG_REV: begin
                n_mode   = jst_pkg::MODE_REV;
                n_stride = (r_stride >= 6'sd0) ? -entry : -jst_pkg::next_rung(-r_stride);
            end
            jst_pkg::CMD_STEP_FWD, jst_pkg::CMD_STEP_BACK: begin
                n_mode     = jst_pkg::MODE_PAUSED;
                n_stride   = '0;
                n_position = clamp_frame(jst_pkg::CMP_BITS'(clamp_in), r_max_frame);
            end
            default: begin
                n_mode   = r_mode;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame <= -33'sd1;
            r_mode      <= jst_pkg::MODE_PAUSED;
            r_stride    <= '0;
            r_position  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_frame <= i_cfg_wdata;
            end
            if (take) begin
                r_mode     <= n_mode;
                r_stride   <= n_stride;
                r_position <= n_position;
            end
            if (advance) begin
                r_out_valid <= i_stage_ctl.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_mode  <= n_mode;
            r_out_speed <= n_stride;
            r_out_frame <= n_position;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.mode  = r_out_mode;
    assign o_res.speed = r_out_speed;
    assign o_res.frame = r_out_frame;

endmodule

`default_nettype wire

FILE: rtl/jog_shuttle_transport_control.sv
// ----------------------------------------------------------------------------
// jog_shuttle_transport_control
// JKL-style transport: command in, mode / signed speed / frame out.
// ----------------------------------------------------------------------------
// Takes one command item per clock while the result sink does not stall, and
// returns one result item per command; the state update loop sets this rate.
// An item passes an input register, then the state update into the result
// register. max_frame (reset -1, negative = no upper clamp) is written through
// i_cfg_we / i_cfg_wdata; the user must write it only while no item is in
// flight, which the block itself does not enforce.
`default_nettype none

module jog_shuttle_transport_control (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic signed [jst_pkg::MAX_BITS-1:0] i_cfg_wdata,
    jst_cmd_if.sink                                  i_cmd,
    jst_res_if.source                                o_res
);

    jst_pkg::t_stage_ctl stage_ctl;
    jst_pkg::t_core_ctl  core_ctl;
    jst_pkg::t_item      item;

    jst_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_core_ctl  (core_ctl),
        .o_stage_ctl (stage_ctl),
        .o_item      (item)
    );

    jst_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_stage_ctl (stage_ctl),
        .i_item      (item),
        .o_core_ctl  (core_ctl),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

FILE: rtl/jst_checker.sv
// ----------------------------------------------------------------------------
// jst_checker
// Port-level checks on the result channel of the transport control.
// ----------------------------------------------------------------------------
`default_nettype none

module jst_checker (
    input wire logic                                  i_clk,
    input wire logic                                  i_rst_n,
    input wire logic                                  i_valid,
    input wire logic                                  i_ready,
    input wire logic [jst_pkg::MODE_BITS-1:0]         i_mode,
    input wire logic signed [jst_pkg::SPEED_BITS-1:0] i_speed,
    input wire logic [jst_pkg::FRAME_BITS-1:0]        i_frame
);

    // no item is shown right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    // stalled item holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_mode) && $stable(i_speed)
            && $stable(i_frame))
        else $error("stalled result changed");

    // direction of the speed follows the mode
    a_mode_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_mode == jst_pkg::MODE_PAUSED && i_speed == 6'sd0)
            || (i_mode == jst_pkg::MODE_FWD && i_speed > 6'sd0)
            || (i_mode == jst_pkg::MODE_REV && i_speed < 6'sd0))
        else $error("speed sign does not match mode");

    // speed sits on the ladder
    a_speed_rung: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_speed == 6'sd0 || i_speed == 6'sd1 || i_speed == 6'sd2
            || i_speed == 6'sd5 || i_speed == 6'sd10 || i_speed == 6'sd30
            || i_speed == -6'sd1 || i_speed == -6'sd2 || i_speed == -6'sd5
            || i_speed == -6'sd10 || i_speed == -6'sd30)
        else $error("speed off the ladder");

endmodule

bind jog_shuttle_transport_control jst_checker u_jst_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_res.valid),
    .i_ready (o_res.ready),
    .i_mode  (o_res.mode),
    .i_speed (o_res.speed),
    .i_frame (o_res.frame)
);

`default_nettype wire

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the jog/shuttle transport control. A predictor
// tracks mode, stride and frame from every accepted command and the frame
// cap from config writes, and holds the expected status in a queue. A checker
// compares each returned status field by field. Directed cases cover the jog
// ladder, toggling, stepping at both ends and the frame cap. A long output
// stall and sender pauses follow; random phases then run under several caps,
// with random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    typedef struct {
        jst_pkg::t_mode                 mode;
        jst_pkg::t_speed                speed;
        logic [jst_pkg::FRAME_BITS-1:0] frame;
    } t_status;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic signed [jst_pkg::MAX_BITS-1:0] i_cfg_wdata;

    jst_cmd_if cmd_ch();
    jst_res_if res_ch();

    jog_shuttle_transport_control u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd_ch),
        .o_res       (res_ch)
    );

    // predictor state
    jst_pkg::t_mode                 pred_mode   = jst_pkg::MODE_PAUSED;
    jst_pkg::t_speed                pred_stride = '0;
    logic [jst_pkg::FRAME_BITS-1:0] pred_frame  = '0;
    logic [jst_pkg::MAX_BITS-1:0]   frame_cap   = {jst_pkg::MAX_BITS{1'b1}};

    t_status     pending_status[$];
    int unsigned error_count    = 0;
    int unsigned items_sent     = 0;
    bit          tx_idle_on     = 1'b0;
    bit          rx_idle_on     = 1'b0;
    int unsigned out_hold_cycles = 0;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    initial begin
        #1000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_error(string msg);
        if (error_count < 100) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
        error_count++;
    endtask

    function automatic logic [jst_pkg::FRAME_BITS-1:0] cap_frame(
        logic [jst_pkg::FRAME_BITS-1:0] f
    );
        if (!frame_cap[jst_pkg::MAX_BITS-1] && ({1'b0, f} > frame_cap)) begin
            return frame_cap[jst_pkg::FRAME_BITS-1:0];
        end
        return f;
    endfunction

    // next ladder rung above mag, holding at 30
    function automatic jst_pkg::t_speed climb_rung(jst_pkg::t_speed mag);
        if (mag < 6'sd1) begin
            return 6'sd1;
        end else if (mag < 6'sd2) begin
            return 6'sd2;
        end else if (mag < 6'sd5) begin
            return 6'sd5;
        end else if (mag < 6'sd10) begin
            return 6'sd10;
        end
        return 6'sd30;
    endfunction

    function automatic t_status step_transport(jst_pkg::t_cmd c, logic two,
                                               logic [jst_pkg::TARGET_BITS-1:0] tgt);
        t_status         s;
        jst_pkg::t_speed entry;
        entry = two ? 6'sd2 : 6'sd1;
        case (c)
            jst_pkg::CMD_NEW_MEDIA: begin
                pred_mode   = jst_pkg::MODE_PAUSED;
                pred_stride = '0;
                pred_frame  = '0;
            end
            jst_pkg::CMD_SET_FRAME: begin
                pred_frame = cap_frame(tgt);
            end
            jst_pkg::CMD_TOGGLE: begin
                if (pred_mode == jst_pkg::MODE_PAUSED) begin
                    pred_mode   = jst_pkg::MODE_FWD;
                    pred_stride = 6'sd1;
                end else begin
                    pred_mode   = jst_pkg::MODE_PAUSED;
                    pred_stride = '0;
                end
            end
            jst_pkg::CMD_PAUSE: begin
                pred_mode   = jst_pkg::MODE_PAUSED;
                pred_stride = '0;
            end
            jst_pkg::CMD_JOG_FWD: begin
                pred_mode   = jst_pkg::MODE_FWD;
                pred_stride = (pred_stride <= 0) ? entry : climb_rung(pred_stride);
            end
            jst_pkg::CMD_JOG_REV: begin
                pred_mode   = jst_pkg::MODE_REV;
                pred_stride = (pred_stride >= 0) ? -entry : -climb_rung(-pred_stride);
            end
            jst_pkg::CMD_STEP_FWD: begin
                pred_mode   = jst_pkg::MODE_PAUSED;
                pred_stride = '0;
                if (pred_frame != jst_pkg::FRAME_TOP) begin
                    pred_frame = pred_frame + 1'b1;
                end
                pred_frame = cap_frame(pred_frame);
            end
            default: begin
                pred_mode   = jst_pkg::MODE_PAUSED;
                pred_stride = '0;
                if (pred_frame != '0) begin
                    pred_frame = pred_frame - 1'b1;
                end
                pred_frame = cap_frame(pred_frame);
            end
        endcase
        s.mode  = pred_mode;
        s.speed = pred_stride;
        s.frame = pred_frame;
        return s;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                frame_cap = i_cfg_wdata;
            end
            if (cmd_ch.valid && cmd_ch.ready) begin
                pending_status.push_back(step_transport(jst_pkg::t_cmd'(cmd_ch.cmd),
                    cmd_ch.enter_at_two, cmd_ch.target_frame));
            end
        end
    end

    always @(posedge i_clk) begin
        t_status exp_s;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_status.size() == 0) begin
                report_error("status item with none expected");
            end else begin
                exp_s = pending_status.pop_front();
                if (res_ch.mode !== exp_s.mode) begin
                    report_error($sformatf("mode: expected %0d, got %0d",
                        exp_s.mode, res_ch.mode));
                end
                if (res_ch.speed !== exp_s.speed) begin
                    report_error($sformatf("speed: expected %0d, got %0d",
                        exp_s.speed, $signed(res_ch.speed)));
                end
                if (res_ch.frame !== exp_s.frame) begin
                    report_error($sformatf("frame: expected %0h, got %0h",
                        exp_s.frame, res_ch.frame));
                end
            end
        end
    end

    // result receiver: random stall per item, plus a requested long hold-off
    initial begin
        int unsigned gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = rx_idle_on ? $urandom_range(0, 11) : 0;
            gap += out_hold_cycles;
            out_hold_cycles = 0;
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    task automatic send_item(jst_pkg::t_cmd c, logic two,
                             logic [jst_pkg::TARGET_BITS-1:0] tgt);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.cmd          <= c;
        cmd_ch.enter_at_two <= two;
        cmd_ch.target_frame <= tgt;
        do @(posedge i_clk); while (!(cmd_ch.valid && cmd_ch.ready));
        items_sent++;
    endtask

    task automatic wait_drain();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_status.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_frame_cap(logic [jst_pkg::MAX_BITS-1:0] v);
        i_cfg_wdata <= v;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [jst_pkg::TARGET_BITS-1:0] pick_target(
        logic [jst_pkg::MAX_BITS-1:0] cap
    );
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 40);
            2: begin
                if (cap[jst_pkg::MAX_BITS-1]) begin
                    return $urandom_range(0, 40);
                end
                return cap[jst_pkg::TARGET_BITS-1:0] + $urandom_range(0, 4) - 2;
            end
            default: return 32'hFFFF_FFFF - $urandom_range(0, 3);
        endcase
    endfunction

    task automatic test_directed_transport();
        wait_drain();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_item(jst_pkg::CMD_TOGGLE, 1'b0, '0);
        send_item(jst_pkg::CMD_TOGGLE, 1'b1, '0);
        repeat (6) send_item(jst_pkg::CMD_JOG_FWD, 1'b0, 32'h5555_5555);
        send_item(jst_pkg::CMD_JOG_REV, 1'b1, 32'hAAAA_AAAA);
        repeat (4) send_item(jst_pkg::CMD_JOG_REV, 1'b0, '0);
        send_item(jst_pkg::CMD_JOG_FWD, 1'b1, '0);
        send_item(jst_pkg::CMD_JOG_FWD, 1'b0, '0);
        send_item(jst_pkg::CMD_TOGGLE, 1'b0, '0);
        send_item(jst_pkg::CMD_STEP_BACK, 1'b0, '0);
        send_item(jst_pkg::CMD_SET_FRAME, 1'b0, 32'hFFFF_FFFF);
        send_item(jst_pkg::CMD_STEP_FWD, 1'b0, '0);
        send_item(jst_pkg::CMD_STEP_BACK, 1'b0, '0);
        send_item(jst_pkg::CMD_JOG_REV, 1'b0, '0);
        send_item(jst_pkg::CMD_NEW_MEDIA, 1'b1, 32'hFFFF_FFFF);
        send_item(jst_pkg::CMD_JOG_FWD, 1'b1, '0);
        send_item(jst_pkg::CMD_PAUSE, 1'b0, '0);
        wait_drain();
    endtask

    task automatic test_frame_cap();
        wait_drain();
        write_frame_cap(33'd10);
        send_item(jst_pkg::CMD_SET_FRAME, 1'b0, 32'd1000);
        send_item(jst_pkg::CMD_STEP_FWD, 1'b0, '0);
        wait_drain();
        // lowering the cap below the frame clamps on the next step
        write_frame_cap(33'd5);
        send_item(jst_pkg::CMD_STEP_BACK, 1'b0, '0);
        wait_drain();
        write_frame_cap({jst_pkg::MAX_BITS{1'b1}});
    endtask

    task automatic test_output_stall();
        wait_drain();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        out_hold_cycles = 80;
        repeat (40) begin
            send_item(jst_pkg::t_cmd'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                pick_target(frame_cap));
        end
        wait_drain();
    endtask

    task automatic test_sender_pause();
        wait_drain();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        repeat (10) send_item(jst_pkg::CMD_JOG_REV, 1'($urandom_range(0, 1)), $urandom());
        wait_drain();
        repeat (10) send_item(jst_pkg::CMD_JOG_REV, 1'($urandom_range(0, 1)), $urandom());
        wait_drain();
    endtask

    task automatic run_random_phase(int unsigned n, logic [jst_pkg::MAX_BITS-1:0] cap);
        int unsigned   stop_at;
        int unsigned   len;
        int unsigned   kind;
        jst_pkg::t_cmd c;
        wait_drain();
        write_frame_cap(cap);
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            kind = $urandom_range(0, 9);
            len  = $urandom_range(1, 7);
            if (kind < 5) begin
                c = $urandom_range(0, 1) ? jst_pkg::CMD_JOG_FWD : jst_pkg::CMD_JOG_REV;
                repeat (len) send_item(c, 1'($urandom_range(0, 1)), $urandom());
            end else if (kind < 8) begin
                send_item(jst_pkg::CMD_SET_FRAME, 1'($urandom_range(0, 1)), pick_target(cap));
                repeat (len) begin
                    c = $urandom_range(0, 1) ? jst_pkg::CMD_STEP_FWD : jst_pkg::CMD_STEP_BACK;
                    send_item(c, 1'($urandom_range(0, 1)), $urandom());
                end
            end else begin
                send_item(jst_pkg::t_cmd'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                    pick_target(cap));
            end
        end
        wait_drain();
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_wdata         <= '0;
        cmd_ch.valid        <= 1'b0;
        cmd_ch.cmd          <= jst_pkg::CMD_NEW_MEDIA;
        cmd_ch.enter_at_two <= 1'b0;
        cmd_ch.target_frame <= '0;
        res_ch.ready        <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_transport();
        test_frame_cap();
        test_output_stall();
        test_sender_pause();
        run_random_phase(160, {jst_pkg::MAX_BITS{1'b1}});
        run_random_phase(160, 33'd0);
        run_random_phase(160, 33'h0_FFFF_FFFF);
        run_random_phase(160, 33'h1_0000_0000);
        run_random_phase(160, {1'b0, 32'($urandom_range(1, 60))});
        run_random_phase(160, {1'b0, $urandom()});
        run_random_phase(160, {1'b1, $urandom()});
        run_random_phase(160, {1'b0, 32'($urandom_range(1, 8))});

        wait_drain();
        repeat (8) @(posedge i_clk);
        if (pending_status.size() != 0) begin
            report_error($sformatf("%0d status items never arrived", pending_status.size()));
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
rtl/jst_pkg.sv
rtl/jst_cmd_if.sv
rtl/jst_res_if.sv
rtl/jst_in_stage.sv
rtl/jst_core.sv
rtl/jog_shuttle_transport_control.sv
rtl/jst_checker.sv
tb/sv/tb_top.sv
